// ===== rtl/umrex_pkg.sv =====
// shared types and constants of the um register execute unit
package umrex_pkg;

   localparam int DATA_W   = 32;
   localparam int REG_W    = 3;
   localparam int IMM_W    = 25;
   localparam int BYTE_W   = 8;
   localparam int NUM_REGS = 8;

   typedef enum logic [3:0] {
      OP_CMOV   = 4'd0,
      OP_LOAD   = 4'd1,
      OP_STORE  = 4'd2,
      OP_ADD    = 4'd3,
      OP_MUL    = 4'd4,
      OP_DIV    = 4'd5,
      OP_NAND   = 4'd6,
      OP_HALT   = 4'd7,
      OP_MAP    = 4'd8,
      OP_UNMAP  = 4'd9,
      OP_OUTPUT = 4'd10,
      OP_INPUT  = 4'd11,
      OP_LOADP  = 4'd12,
      OP_LOADV  = 4'd13
   } opcode_type;

   typedef enum logic [3:0] {
      KIND_DONE  = 4'd0,
      KIND_OUT   = 4'd1,
      KIND_LOAD  = 4'd2,
      KIND_STORE = 4'd3,
      KIND_MAP   = 4'd4,
      KIND_UNMAP = 4'd5,
      KIND_LOADP = 4'd6,
      KIND_HALT  = 4'd7,
      KIND_DIVF  = 4'd8,
      KIND_OUTF  = 4'd9
   } kind_type;

   localparam logic ACTION_EXEC   = 1'b0;
   localparam logic ACTION_RETURN = 1'b1;

   localparam logic [DATA_W-1:0] BYTE_MAX = DATA_W'(255);

   typedef struct packed {
      logic               action;
      logic [3:0]         opcode;
      logic [REG_W-1:0]   reg_a;
      logic [REG_W-1:0]   reg_b;
      logic [REG_W-1:0]   reg_c;
      logic [IMM_W-1:0]   immediate;
      logic [BYTE_W-1:0]  in_byte;
      logic               in_eof;
      logic [DATA_W-1:0]  return_word;
   } req_payload_type;

   typedef struct packed {
      kind_type           kind;
      logic [BYTE_W-1:0]  out_byte;
      logic [DATA_W-1:0]  seg_id;
      logic [DATA_W-1:0]  offset;
      logic [DATA_W-1:0]  store_data;
      logic [DATA_W-1:0]  new_pc;
      logic [REG_W-1:0]   dest_reg;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic read_a;
      logic div_start;
      logic finish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_store;
      logic req_div;
      logic div_zero;
      logic div_busy;
   } dp_status_type;

endpackage

// ===== rtl/umrex_if.sv =====
// valid/ready channel interfaces for requests and responses
interface umrex_req_if;
   logic                       valid;
   logic                       ready;
   umrex_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface umrex_rsp_if;
   logic                       valid;
   logic                       ready;
   umrex_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/umrex_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module umrex_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [umrex_pkg::DATA_W-1:0]  dividend,
   input  logic [umrex_pkg::DATA_W-1:0]  divisor,
   output logic                          busy,
   output logic [umrex_pkg::DATA_W-1:0]  quotient
);
   import umrex_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff;
   logic              busy_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [DATA_W-1:0] quo_ff;
   logic [DATA_W-1:0] quo_in;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] rem_in;
   logic [DATA_W-1:0] dvs_ff;
   logic [DATA_W-1:0] dvs_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   trial;

   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/umrex_ctrl.sv =====
// sequencing state machine and response valid of the execute unit
module umrex_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  umrex_pkg::dp_status_type  status,
   output umrex_pkg::ctrl_cmd_type   cmd
);
   import umrex_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_READ_A    = 5'b00010,
      ST_DIV_START = 5'b00100,
      ST_DIV_WAIT  = 5'b01000,
      ST_EXEC      = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.req_store) begin
                  state_in = ST_READ_A;
               end else if (status.req_div) begin
                  state_in = ST_DIV_START;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_READ_A: begin
            cmd.read_a = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_DIV_START: begin
            if (status.div_zero) begin
               state_in = ST_EXEC;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/umrex_dp.sv =====
// register file, operand registers, alu and response register
module umrex_dp #(
   parameter int NUM_REGS = umrex_pkg::NUM_REGS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  umrex_pkg::req_payload_type  req_payload,
   input  umrex_pkg::ctrl_cmd_type     cmd,
   output umrex_pkg::dp_status_type    status,
   output umrex_pkg::rsp_payload_type  rsp_payload
);
   import umrex_pkg::*;

   localparam int IDX_W = $clog2(NUM_REGS);

   logic [DATA_W-1:0]   regs_mem [NUM_REGS];
   logic [NUM_REGS-1:0] vld_ff;

   // captured request
   logic               action_ff;
   logic [3:0]         op_ff;
   logic [REG_W-1:0]   a_ff;
   logic [REG_W-1:0]   b_ff;
   logic [REG_W-1:0]   c_ff;
   logic [IMM_W-1:0]   imm_ff;
   logic [BYTE_W-1:0]  byte_ff;
   logic               eof_ff;
   logic [DATA_W-1:0]  ret_ff;

   // registered read ports
   logic [IDX_W-1:0]   rd0_addr;
   logic               rd0_en;
   logic [DATA_W-1:0]  rd0_ff;
   logic               rd0_vld_ff;
   logic [DATA_W-1:0]  rd1_ff;
   logic               rd1_vld_ff;
   logic [DATA_W-1:0]  rb_hold_ff;

   logic [DATA_W-1:0]  rd0_val;
   logic [DATA_W-1:0]  ra;
   logic [DATA_W-1:0]  rb;
   logic [DATA_W-1:0]  rc;
   logic               is_store;
   logic [DATA_W-1:0]  product;
   logic               div_busy;
   logic [DATA_W-1:0]  quotient;

   logic               wr_en;
   logic [REG_W-1:0]   wr_sel;
   logic [DATA_W-1:0]  wr_data;
   logic [IDX_W-1:0]   wr_addr;

   rsp_payload_type    rsp_ff;
   rsp_payload_type    rsp_in;

   // port 0 reads b at capture and a in the read_a state of a store
   assign rd0_addr = cmd.read_a ? IDX_W'(a_ff) : IDX_W'(req_payload.reg_b);
   assign rd0_en   = cmd.capture || cmd.read_a;

   always_ff @(posedge clock) begin
      if (rd0_en) begin
         rd0_ff     <= regs_mem[rd0_addr];
         rd0_vld_ff <= vld_ff[rd0_addr];
      end
      if (cmd.capture) begin
         rd1_ff     <= regs_mem[IDX_W'(req_payload.reg_c)];
         rd1_vld_ff <= vld_ff[IDX_W'(req_payload.reg_c)];
         action_ff  <= req_payload.action;
         op_ff      <= req_payload.opcode;
         a_ff       <= req_payload.reg_a;
         b_ff       <= req_payload.reg_b;
         c_ff       <= req_payload.reg_c;
         imm_ff     <= req_payload.immediate;
         byte_ff    <= req_payload.in_byte;
         eof_ff     <= req_payload.in_eof;
         ret_ff     <= req_payload.return_word;
      end
      if (cmd.read_a) begin
         rb_hold_ff <= rd0_val;
      end
   end

   assign rd0_val  = rd0_vld_ff ? rd0_ff : '0;
   assign rc       = rd1_vld_ff ? rd1_ff : '0;
   assign is_store = (action_ff == ACTION_EXEC) && (op_ff == OP_STORE);
   assign ra       = rd0_val;
   assign rb       = is_store ? rb_hold_ff : rd0_val;
   assign product  = DATA_W'(rb * rc);

   umrex_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rb),
      .divisor  (rc),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign status.req_store = (req_payload.action == ACTION_EXEC)
                             && (req_payload.opcode == OP_STORE);
   assign status.req_div   = (req_payload.action == ACTION_EXEC)
                             && (req_payload.opcode == OP_DIV);
   assign status.div_zero  = (rc == '0);
   assign status.div_busy  = div_busy;

   always_comb begin
      rsp_in  = '0;
      rsp_in.kind = KIND_DONE;
      wr_en   = 1'b0;
      wr_sel  = a_ff;
      wr_data = '0;
      if (action_ff == ACTION_RETURN) begin
         wr_en   = 1'b1;
         wr_data = ret_ff;
      end else begin
         unique case (op_ff)
            OP_CMOV: begin
               wr_en   = (rc != '0);
               wr_data = rb;
            end
            OP_LOAD: begin
               rsp_in.kind     = KIND_LOAD;
               rsp_in.seg_id   = rb;
               rsp_in.offset   = rc;
               rsp_in.dest_reg = a_ff;
            end
            OP_STORE: begin
               rsp_in.kind       = KIND_STORE;
               rsp_in.seg_id     = ra;
               rsp_in.offset     = rb;
               rsp_in.store_data = rc;
            end
            OP_ADD: begin
               wr_en   = 1'b1;
               wr_data = rb + rc;
            end
            OP_MUL: begin
               wr_en   = 1'b1;
               wr_data = product;
            end
            OP_DIV: begin
               if (rc == '0) begin
                  rsp_in.kind = KIND_DIVF;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = quotient;
               end
            end
            OP_NAND: begin
               wr_en   = 1'b1;
               wr_data = ~(rb & rc);
            end
            OP_HALT: begin
               rsp_in.kind = KIND_HALT;
            end
            OP_MAP: begin
               rsp_in.kind     = KIND_MAP;
               rsp_in.offset   = rc;
               rsp_in.dest_reg = b_ff;
            end
            OP_UNMAP: begin
               rsp_in.kind   = KIND_UNMAP;
               rsp_in.seg_id = rc;
            end
            OP_OUTPUT: begin
               if (rc > BYTE_MAX) begin
                  rsp_in.kind = KIND_OUTF;
               end else begin
                  rsp_in.kind     = KIND_OUT;
                  rsp_in.out_byte = rc[BYTE_W-1:0];
               end
            end
            OP_INPUT: begin
               wr_en   = 1'b1;
               wr_sel  = c_ff;
               wr_data = eof_ff ? '1 : DATA_W'(byte_ff);
            end
            OP_LOADP: begin
               rsp_in.kind   = KIND_LOADP;
               rsp_in.seg_id = rb;
               rsp_in.new_pc = rc;
            end
            OP_LOADV: begin
               wr_en   = 1'b1;
               wr_data = DATA_W'(imm_ff);
            end
            default: begin
               // unused opcodes leave everything as is
            end
         endcase
      end
   end

   assign wr_addr = IDX_W'(wr_sel);

   always_ff @(posedge clock) begin
      if (cmd.finish && wr_en) begin
         regs_mem[wr_addr] <= wr_data;
      end
   end

   // an entry never written since reset reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.finish && wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/um_register_execute_unit_top.sv =====
// top level of the um register execute unit
// usage
//   req_if carries one request per instruction: action 0 executes the decoded
//   opcode on the eight-word register file, action 1 writes return_word (a
//   loaded word or a new segment id) into register reg_a
//   rsp_if returns exactly one response per request, in request order: kind
//   done for pure register work, or a memory/output/halt request, or a fault
//   (divide by zero, output above 255) with the register file untouched
// sequencing
//   after acceptance most requests go straight to the execute step; store first
//   makes a second pass over read port 0 to fetch register a, and divide passes
//   the divide start state (and for a nonzero divisor waits while the divider,
//   which retires one quotient bit per cycle, is busy) before the execute step
//   one request is in flight at a time; req_if.ready is high only while idle
// reset
//   synchronous, active high; all registers read as zero, no response pending
// stalls
//   the response sits in an output register; a new request is accepted while
//   it waits, and only the execute step holds until the register is free
module um_register_execute_unit_top #(
   parameter int NUM_REGS = umrex_pkg::NUM_REGS
) (
   input logic         clock,
   input logic         reset,
   umrex_req_if.sink   req_if,
   umrex_rsp_if.source rsp_if
);
   import umrex_pkg::*;

   // command and status between sequencer and datapath
   ctrl_cmd_type  cmd;
   dp_status_type status;

   umrex_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   umrex_dp #(
      .NUM_REGS (NUM_REGS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_if.payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_if.payload)
   );

`ifndef SYNTHESIS
   // an accepted request takes the sequencer out of idle
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while a request is still in flight");

   // a response only appears after an execute step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(cmd.finish))
      else $error("response valid without an execute step");

   // the execute step never overwrites a response that is still held
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_if.valid || rsp_if.ready))
      else $error("pending response overwritten");

   // a divide start always brings the divider busy
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider did not start");
`endif

endmodule
